### hw/rtl/svpwm_pkg.sv
package svpwm_pkg;

  // Sector codes, 60 degrees each, counted from the positive alpha axis.
  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_e;

  // Configuration register indexes, one 32-bit word each.
  typedef enum logic [2:0] {
    REG_BUS_GAIN,
    REG_OFFSET_A,
    REG_OFFSET_B,
    REG_OFFSET_C,
    REG_HALF_PERIOD
  } reg_idx_e;

  // Classified item handed from the front end to the duty pipeline.
  typedef struct packed {
    logic               stop;
    logic signed [31:0] mb;
    logic signed [31:0] ma;
    sector_e            sector;
  } front_item_t;

  // Configuration that the duty pipeline reads.
  typedef struct packed {
    logic signed [31:0] offset_a;
    logic signed [31:0] offset_b;
    logic signed [31:0] offset_c;
    logic [15:0]        half_period;
  } cfg_t;

  // Integer square root, used only to build coefficient constants at elaboration.
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bits;
    rem  = n;
    res  = '0;
    bits = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bits > rem) begin
        bits = bits >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bits != 64'd0) begin
        if (rem >= res + bits) begin
          rem = rem - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/svpwm_front.sv
module svpwm_front #(
  parameter int unsigned Q_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [31:0]     alpha_i,
  input  logic signed [31:0]     beta_i,
  input  logic                   stop_i,
  input  logic signed [31:0]     bus_gain_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output svpwm_pkg::front_item_t out_item_o
);
  import svpwm_pkg::*;

  logic               v1_q, v2_q;
  logic               rdy1, rdy2;
  logic [31:0]        aa, bb;
  logic signed [31:0] gain_abs;
  logic [63:0]        a2_d, b2_d;
  logic signed [63:0] pa_d, pb_d;
  logic [63:0]        a2_q, b2_q;
  logic signed [63:0] pa_q, pb_q;
  logic               a_neg_q, a_zero_q, b_neg_q, b_zero_q, stop1_q;
  logic [63:0]        a3;
  logic               b_lt, b_gt;
  sector_e            sec_d;
  front_item_t        item_q;

  // Two elastic stages: each loads when it is empty or its successor takes.
  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Magnitudes for the sector test; the gain magnitude wraps at the minimum.
  assign aa       = alpha_i[31] ? 32'(-alpha_i) : 32'(alpha_i);
  assign bb       = beta_i[31] ? 32'(-beta_i) : 32'(beta_i);
  assign gain_abs = bus_gain_i[31] ? -bus_gain_i : bus_gain_i;

  // Stage one multipliers: squares for the sector and the gain products.
  assign a2_d = aa * aa;
  assign b2_d = bb * bb;
  assign pa_d = alpha_i * gain_abs;
  assign pb_d = beta_i * gain_abs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      a2_q     <= a2_d;
      b2_q     <= b2_d;
      pa_q     <= pa_d;
      pb_q     <= pb_d;
      a_neg_q  <= alpha_i[31];
      a_zero_q <= (alpha_i == 32'sd0);
      b_neg_q  <= beta_i[31];
      b_zero_q <= (beta_i == 32'sd0);
      stop1_q  <= stop_i;
    end
    if (rdy2 && v1_q) begin
      item_q.sector <= sec_d;
      item_q.ma     <= pa_q[Q_BITS+31:Q_BITS];
      item_q.mb     <= pb_q[Q_BITS+31:Q_BITS];
      item_q.stop   <= stop1_q;
    end
  end

  // The 60 degree line is beta^2 == 3 alpha^2; exact boundaries go to the higher sector.
  assign a3   = (a2_q << 1) + a2_q;
  assign b_lt = b2_q < a3;
  assign b_gt = b2_q > a3;

  always_comb begin
    sec_d = SEC_5;
    if (b_zero_q) begin
      sec_d = a_neg_q ? SEC_3 : SEC_0;
    end else if (!b_neg_q) begin
      if (a_zero_q) begin
        sec_d = SEC_1;
      end else if (!a_neg_q) begin
        sec_d = b_lt ? SEC_0 : SEC_1;
      end else begin
        sec_d = b_gt ? SEC_1 : SEC_2;
      end
    end else begin
      if (a_zero_q) begin
        sec_d = SEC_4;
      end else if (a_neg_q) begin
        sec_d = b_lt ? SEC_3 : SEC_4;
      end else begin
        sec_d = b_gt ? SEC_4 : SEC_5;
      end
    end
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item_q;

endmodule

### hw/rtl/svpwm_fifo.sv
module svpwm_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  svpwm_pkg::front_item_t in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output svpwm_pkg::front_item_t out_item_o
);
  import svpwm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  front_item_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign in_ready_o  = (count_q != CNT_W'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  // Pointers wrap at the depth; the count tracks the fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill level above depth");

  a_count_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("queue fill level did not follow a push");
`endif

endmodule

### hw/rtl/svpwm_back.sv
module svpwm_back #(
  parameter int unsigned Q_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  svpwm_pkg::front_item_t in_item_i,
  input  svpwm_pkg::cfg_t        cfg_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output svpwm_pkg::sector_e     sector_o,
  output logic [Q_BITS:0]        duty_a_o,
  output logic [Q_BITS:0]        duty_b_o,
  output logic [Q_BITS:0]        duty_c_o,
  output logic [15:0]            compare_a_o,
  output logic [15:0]            compare_b_o,
  output logic [15:0]            compare_c_o,
  output logic                   forced_low_o
);
  import svpwm_pkg::*;

  localparam int unsigned DUTY_W = Q_BITS + 1;
  localparam int unsigned CMP_W  = 16 + DUTY_W;
  localparam logic signed [31:0] KC  = 32'(isqrt64(64'd3 << (2 * Q_BITS - 1)));
  localparam logic signed [31:0] KH  = 32'(isqrt64(64'd1 << (2 * Q_BITS - 1)));
  localparam logic signed [31:0] KR  = 32'(isqrt64(64'd2 << (2 * Q_BITS)));
  localparam logic signed [31:0] ONE = 32'(64'd1 << Q_BITS);

  logic [4:0]         v_q;
  logic [4:0]         rdy;

  logic signed [31:0] xa, ya, xb, yb;
  logic signed [63:0] p0, p1, p2, p3;
  logic signed [31:0] q0_q, q1_q, q2_q, q3_q;
  sector_e            sec1_q, sec2_q, sec3_q, sec4_q, sec5_q;
  logic               stop1_q, stop2_q, stop3_q, stop4_q, stop5_q;

  logic signed [31:0] t1_d, t12_d, t1_q, t12_q;
  logic signed [31:0] t3, h, ds, dt;
  logic signed [31:0] da_d, db_d, dc_d, da_q, db_q, dc_q;
  logic signed [31:0] ea, eb, ec;
  logic [DUTY_W-1:0]  ca, cb, cc;
  logic [DUTY_W-1:0]  duty_a_q, duty_b_q, duty_c_q;
  logic [DUTY_W-1:0]  duty_a5_q, duty_b5_q, duty_c5_q;
  logic [CMP_W-1:0]   pa, pb, pc;
  logic [15:0]        cmp_a_q, cmp_b_q, cmp_c_q;

  // Five elastic stages; a stage loads when it is empty or its successor takes.
  assign rdy[4]     = !v_q[4] || out_ready_i;
  assign rdy[3]     = !v_q[3] || rdy[4];
  assign rdy[2]     = !v_q[2] || rdy[3];
  assign rdy[1]     = !v_q[1] || rdy[2];
  assign rdy[0]     = !v_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
    end
  end

  // Sector coefficient sets for T1 (xa, ya) and T2 (xb, yb).
  always_comb begin
    case (in_item_i.sector)
      SEC_0: begin
        xa = KC;  ya = -KH; xb = '0;  yb = KR;
      end
      SEC_1: begin
        xa = -KC; ya = KH;  xb = KC;  yb = KH;
      end
      SEC_2: begin
        xa = '0;  ya = KR;  xb = -KC; yb = -KH;
      end
      SEC_3: begin
        xa = '0;  ya = -KR; xb = -KC; yb = KH;
      end
      SEC_4: begin
        xa = -KC; ya = -KH; xb = KC;  yb = -KH;
      end
      default: begin
        xa = KC;  ya = KH;  xb = '0;  yb = -KR;
      end
    endcase
  end

  assign p0 = xa * in_item_i.ma;
  assign p1 = ya * in_item_i.mb;
  assign p2 = xb * in_item_i.ma;
  assign p3 = yb * in_item_i.mb;

  // Active times; T1 + T2 is formed as a balanced sum.
  assign t1_d  = q0_q + q1_q;
  assign t12_d = (q0_q + q1_q) + (q2_q + q3_q);

  // Zero time split in half, then the three stacked duties.
  assign t3 = ONE - t12_q;
  assign h  = t3 >>> 1;
  assign ds = h + t1_q;
  assign dt = h + t12_q;

  // Phase order of the stacked duties for each sector.
  always_comb begin
    case (sec2_q)
      SEC_0: begin
        da_d = h;  db_d = ds; dc_d = dt;
      end
      SEC_1: begin
        da_d = ds; db_d = h;  dc_d = dt;
      end
      SEC_2: begin
        da_d = dt; db_d = h;  dc_d = ds;
      end
      SEC_3: begin
        da_d = dt; db_d = ds; dc_d = h;
      end
      SEC_4: begin
        da_d = ds; db_d = dt; dc_d = h;
      end
      default: begin
        da_d = h;  db_d = dt; dc_d = ds;
      end
    endcase
  end

  // Inversion, phase offset and clamp to the range zero to one.
  assign ea = ONE - da_q + cfg_i.offset_a;
  assign eb = ONE - db_q + cfg_i.offset_b;
  assign ec = ONE - dc_q + cfg_i.offset_c;
  assign ca = (ea > ONE) ? DUTY_W'(ONE) : (ea < 0) ? '0 : ea[DUTY_W-1:0];
  assign cb = (eb > ONE) ? DUTY_W'(ONE) : (eb < 0) ? '0 : eb[DUTY_W-1:0];
  assign cc = (ec > ONE) ? DUTY_W'(ONE) : (ec < 0) ? '0 : ec[DUTY_W-1:0];

  // Compare counts from the half period.
  assign pa = cfg_i.half_period * duty_a_q;
  assign pb = cfg_i.half_period * duty_b_q;
  assign pc = cfg_i.half_period * duty_c_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      q0_q    <= p0[Q_BITS+31:Q_BITS];
      q1_q    <= p1[Q_BITS+31:Q_BITS];
      q2_q    <= p2[Q_BITS+31:Q_BITS];
      q3_q    <= p3[Q_BITS+31:Q_BITS];
      sec1_q  <= in_item_i.sector;
      stop1_q <= in_item_i.stop;
    end
    if (rdy[1] && v_q[0]) begin
      t1_q    <= t1_d;
      t12_q   <= t12_d;
      sec2_q  <= sec1_q;
      stop2_q <= stop1_q;
    end
    if (rdy[2] && v_q[1]) begin
      da_q    <= da_d;
      db_q    <= db_d;
      dc_q    <= dc_d;
      sec3_q  <= sec2_q;
      stop3_q <= stop2_q;
    end
    if (rdy[3] && v_q[2]) begin
      duty_a_q <= ca;
      duty_b_q <= cb;
      duty_c_q <= cc;
      sec4_q   <= sec3_q;
      stop4_q  <= stop3_q;
    end
    if (rdy[4] && v_q[3]) begin
      duty_a5_q <= duty_a_q;
      duty_b5_q <= duty_b_q;
      duty_c5_q <= duty_c_q;
      cmp_a_q   <= pa[Q_BITS+15:Q_BITS];
      cmp_b_q   <= pb[Q_BITS+15:Q_BITS];
      cmp_c_q   <= pc[Q_BITS+15:Q_BITS];
      sec5_q    <= sec4_q;
      stop5_q   <= stop4_q;
    end
  end

  assign out_valid_o  = v_q[4];
  assign sector_o     = sec5_q;
  assign duty_a_o     = duty_a5_q;
  assign duty_b_o     = duty_b5_q;
  assign duty_c_o     = duty_c5_q;
  assign compare_a_o  = cmp_a_q;
  assign compare_b_o  = cmp_b_q;
  assign compare_c_o  = cmp_c_q;
  assign forced_low_o = stop5_q;

`ifndef NO_ASSERTIONS
  a_sector_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (sec5_q <= SEC_5))
    else $error("sector out of range on a delivered item");

  a_duty_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> ((duty_a5_q <= DUTY_W'(ONE)) && (duty_b5_q <= DUTY_W'(ONE))
                && (duty_c5_q <= DUTY_W'(ONE))))
    else $error("duty above one on a delivered item");
`endif

endmodule

### hw/rtl/svpwm_duty_generator_top.sv
// Space-vector PWM duty generator with an APB register port.
// Path: an accepted item passes two front stages for the sector and gain multiplies,
// one queue slot and five duty stages. Throughput: one item per cycle while m_axis_tready
// is high, set by the fully pipelined multipliers in both parts.
// Reset (rst_ni low, asynchronous) empties all stages and the queue, sets bus_gain to 1.0
// and the phase offsets and half period to zero.
module svpwm_duty_generator_top #(
  parameter int unsigned Q_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // alpha [31:0], beta [63:32], stop_request [64], zero fill above
  input  logic [71:0]                             s_axis_tdata,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // sector, duty_a, duty_b, duty_c, compare_a, compare_b, compare_c, forced_low,
  // from the lowest bit up, zero fill to whole bytes
  output logic [(((3 * (Q_BITS + 1) + 52) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [4:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import svpwm_pkg::*;

  localparam int unsigned DUTY_W     = Q_BITS + 1;
  localparam int unsigned OUT_W      = (((3 * DUTY_W + 52) + 7) / 8) * 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [31:0] GAIN_RESET = 32'(64'd1 << Q_BITS);

  logic signed [31:0] bus_gain_q, offset_a_q, offset_b_q, offset_c_q;
  logic [15:0]        half_period_q;
  logic               cfg_we;
  reg_idx_e           cfg_idx;
  cfg_t               cfg;

  logic               front_valid, front_ready;
  front_item_t        front_item;
  logic               back_valid, back_ready;
  front_item_t        back_item;

  sector_e            sector;
  logic [DUTY_W-1:0]  duty_a, duty_b, duty_c;
  logic [15:0]        compare_a, compare_b, compare_c;
  logic               forced_low;

  // Register port: writes complete in the access phase, reads are combinational.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_gain_q    <= GAIN_RESET;
      offset_a_q    <= '0;
      offset_b_q    <= '0;
      offset_c_q    <= '0;
      half_period_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BUS_GAIN:    bus_gain_q    <= pwdata;
        REG_OFFSET_A:    offset_a_q    <= pwdata;
        REG_OFFSET_B:    offset_b_q    <= pwdata;
        REG_OFFSET_C:    offset_c_q    <= pwdata;
        REG_HALF_PERIOD: half_period_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BUS_GAIN:    prdata = bus_gain_q;
      REG_OFFSET_A:    prdata = offset_a_q;
      REG_OFFSET_B:    prdata = offset_b_q;
      REG_OFFSET_C:    prdata = offset_c_q;
      REG_HALF_PERIOD: prdata = {16'd0, half_period_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg.offset_a    = offset_a_q;
  assign cfg.offset_b    = offset_b_q;
  assign cfg.offset_c    = offset_c_q;
  assign cfg.half_period = half_period_q;

  // Front end: sector classification and gain scaling.
  svpwm_front #(
    .Q_BITS(Q_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .alpha_i    (s_axis_tdata[31:0]),
    .beta_i     (s_axis_tdata[63:32]),
    .stop_i     (s_axis_tdata[64]),
    .bus_gain_i (bus_gain_q),
    .out_valid_o(front_valid),
    .out_ready_i(front_ready),
    .out_item_o (front_item)
  );

  // Queue between the front end and the duty pipeline.
  svpwm_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (front_valid),
    .in_ready_o (front_ready),
    .in_item_i  (front_item),
    .out_valid_o(back_valid),
    .out_ready_i(back_ready),
    .out_item_o (back_item)
  );

  // Duty pipeline: active times, ordering, clamp and compare counts.
  svpwm_back #(
    .Q_BITS(Q_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (back_valid),
    .in_ready_o  (back_ready),
    .in_item_i   (back_item),
    .cfg_i       (cfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sector_o    (sector),
    .duty_a_o    (duty_a),
    .duty_b_o    (duty_b),
    .duty_c_o    (duty_c),
    .compare_a_o (compare_a),
    .compare_b_o (compare_b),
    .compare_c_o (compare_c),
    .forced_low_o(forced_low)
  );

  // Result packing, first field in the lowest bits.
  assign m_axis_tdata = OUT_W'({forced_low, compare_c, compare_b, compare_a,
                                duty_c, duty_b, duty_a, 3'(sector)});

endmodule
